>>> rtl/core/hall_tachometer_rpm_average_defines.svh
// assertion macros for the hall tachometer checker
// depends on: nothing; expects clk and arst_n in the scope of use
`ifndef HALL_TACHOMETER_RPM_AVERAGE_DEFINES_SVH
`define HALL_TACHOMETER_RPM_AVERAGE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define HTA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define HTA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/hta_pkg.sv
// shared types and constants of the hall tachometer
// depends on: nothing
package hta_pkg;

	// fixed-point constants: 60000 ms/min in Q.8, rpm ceiling, 2*pi/60 in Q.16
	localparam logic [23:0] RPM_SCALE_Q8 = 24'd15360000;
	localparam logic [17:0] RPM_MAX_Q8   = 18'h3FFFF;
	localparam logic [12:0] RADPS_FACTOR = 13'd6863;
	localparam logic [15:0] MIN_PERIOD_RESET = 16'd100;
	// periods below this give more than the rpm ceiling
	localparam logic [31:0] SAT_PERIOD = 32'd59;
	localparam int unsigned DIV_STEPS = 24;
	localparam int unsigned CNT_W     = 5;

	// datapath operations
	typedef enum logic [2:0] {
		OP_LOAD,
		OP_NONE,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_AVG,
		OP_SAT,
		OP_MUL,
		OP_OUT
	} op_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_IN,
		C_NO_MEAS,
		C_SAT,
		C_DIV_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef logic [2:0] step_t;

	// program addresses
	localparam step_t STEP_IDLE  = 3'd0;
	localparam step_t STEP_CHECK = 3'd1;
	localparam step_t STEP_INIT  = 3'd2;
	localparam step_t STEP_DIV   = 3'd3;
	localparam step_t STEP_AVG   = 3'd4;
	localparam step_t STEP_SAT   = 3'd5;
	localparam step_t STEP_MUL   = 3'd6;
	localparam step_t STEP_OUT   = 3'd7;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	// sequencer to datapath
	typedef struct packed {
		op_t op;
	} ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic in_valid;
		logic no_meas;
		logic sat;
		logic div_more;
		logic out_busy;
	} stat_t;

endpackage

>>> rtl/core/hall_tachometer_rpm_average.sv
// top level of the hall tachometer with running rpm average
// depends on: hta_pkg, hta_useq, hta_dp
//
// channel   direction  payload
// s_axis    in         tdata: now_ms[31:0]; tuser: edge_mask[1:0]
// m_axis    out        tdata: led_level, period_ms, avg_rpm_q8, radps_q8; tuser: accepted
// cfg       in         cfg_wdata: min_period_ms[15:0], written when cfg_we is high
//
// an event with a measurement runs one in, one check and one divider set-up step,
// 24 restoring divide steps, then average, multiply and output steps; a saturating
// measurement saturates instead of dividing; an event without one skips to multiply
// s_axis_tready is high only on the idle step of the microprogram
// the output step waits while the output register holds an untaken transaction
// reset clears the architectural state and output valid and sets min_period_ms to 100
module hall_tachometer_rpm_average (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,     // min_period_ms
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // now_ms
	input  logic [1:0]  s_axis_tuser,  // edge_mask
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // led_level, period_ms, avg_rpm_q8, radps_q8, zero pad
	output logic [0:0]  m_axis_tuser   // accepted
);
	import hta_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	// microprogram
	hta_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// datapath
	hta_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

>>> rtl/core/hta_useq.sv
// microcode sequencer: program rom, step counter and conditional jumps
// depends on: hta_pkg
module hta_useq (
	input  logic           clk,
	input  logic           arst_n,
	input  hta_pkg::stat_t stat,
	output hta_pkg::ctrl_t ctrl
);
	import hta_pkg::*;

	step_t  step_q;
	uword_t uw;
	logic   jump;

	// program rom
	always_comb begin
		unique case (step_q)
			STEP_IDLE:  uw = '{op: OP_LOAD,     cond: C_NO_IN,    target: STEP_IDLE};
			STEP_CHECK: uw = '{op: OP_NONE,     cond: C_NO_MEAS,  target: STEP_MUL};
			STEP_INIT:  uw = '{op: OP_DIV_INIT, cond: C_SAT,      target: STEP_SAT};
			STEP_DIV:   uw = '{op: OP_DIV_STEP, cond: C_DIV_MORE, target: STEP_DIV};
			STEP_AVG:   uw = '{op: OP_AVG,      cond: C_ALWAYS,   target: STEP_MUL};
			STEP_SAT:   uw = '{op: OP_SAT,      cond: C_ALWAYS,   target: STEP_AVG};
			STEP_MUL:   uw = '{op: OP_MUL,      cond: C_NEVER,    target: STEP_IDLE};
			// falls through to the idle step by counter wrap
			STEP_OUT:   uw = '{op: OP_OUT,      cond: C_OUT_BUSY, target: STEP_OUT};
			default:    uw = '{op: OP_NONE,     cond: C_ALWAYS,   target: STEP_IDLE};
		endcase
	end

	// condition select
	always_comb begin
		unique case (uw.cond)
			C_NEVER:    jump = 1'b0;
			C_ALWAYS:   jump = 1'b1;
			C_NO_IN:    jump = !stat.in_valid;
			C_NO_MEAS:  jump = stat.no_meas;
			C_SAT:      jump = stat.sat;
			C_DIV_MORE: jump = stat.div_more;
			C_OUT_BUSY: jump = stat.out_busy;
			default:    jump = 1'b0;
		endcase
	end

	assign ctrl.op = uw.op;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else if (jump) begin
			step_q <= uw.target;
		end else begin
			step_q <= step_q + 3'd1;
		end
	end

endmodule

>>> rtl/core/hta_dp.sv
// datapath: state, restoring divider, average, rad/s multiplier, output register
// depends on: hta_pkg
module hta_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  hta_pkg::ctrl_t ctrl,
	output hta_pkg::stat_t stat,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_wdata,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  logic [31:0]    s_axis_tdata,
	input  logic [1:0]     s_axis_tuser,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [71:0]    m_axis_tdata,
	output logic [0:0]     m_axis_tuser
);
	import hta_pkg::*;

	logic [15:0]      min_period_q;
	logic             led_q;
	logic [31:0]      last_edge_q;
	logic [17:0]      avg_q;
	logic [31:0]      last_period_q;
	logic             acc_q;
	logic             rise_q;
	logic [31:0]      now_q;
	logic [31:0]      per_q;
	logic [23:0]      rem_q;
	logic [23:0]      quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [30:0]      prod_q;

	logic             out_valid_q;
	logic             out_led_q;
	logic             out_acc_q;
	logic [31:0]      out_period_q;
	logic [17:0]      out_avg_q;
	logic [14:0]      out_radps_q;

	logic             in_acc;
	logic             out_load;
	logic [24:0]      rem_sh;
	logic [31:0]      rem_diff;
	logic             rem_ge;
	logic [18:0]      avg_sum;

	assign s_axis_tready = (ctrl.op == OP_LOAD);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// status back to the sequencer
	assign stat.in_valid = s_axis_tvalid;
	assign stat.no_meas  = !rise_q || (per_q < {16'd0, min_period_q});
	assign stat.sat      = (per_q < SAT_PERIOD);
	assign stat.div_more = (cnt_q != '0);
	assign stat.out_busy = out_valid_q && !m_axis_tready;

	// one restoring divide step
	assign rem_sh   = {rem_q, quo_q[23]};
	assign rem_diff = {7'd0, rem_sh} - per_q;
	assign rem_ge   = ({7'd0, rem_sh} >= per_q);

	assign avg_sum  = {1'b0, quo_q[17:0]} + {1'b0, avg_q};
	assign out_load = (ctrl.op == OP_OUT) && !stat.out_busy;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_period_q <= MIN_PERIOD_RESET;
		end else if (cfg_we) begin
			min_period_q <= cfg_wdata;
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q         <= 1'b0;
			last_edge_q   <= '0;
			avg_q         <= '0;
			last_period_q <= '0;
			acc_q         <= 1'b0;
			rise_q        <= 1'b0;
		end else begin
			if (in_acc) begin
				rise_q <= s_axis_tuser[1];
				acc_q  <= 1'b0;
				// rising edge wins over falling edge
				if (s_axis_tuser[1]) begin
					led_q <= 1'b0;
				end else if (s_axis_tuser[0]) begin
					led_q <= 1'b1;
				end
			end
			if (ctrl.op == OP_AVG) begin
				avg_q         <= avg_sum[18:1];
				last_period_q <= per_q;
				last_edge_q   <= now_q;
				acc_q         <= 1'b1;
			end
		end
	end

	// working registers: period, divider, product
	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_q <= s_axis_tdata;
			per_q <= s_axis_tdata - last_edge_q;
		end
		case (ctrl.op)
			OP_DIV_INIT: begin
				rem_q <= '0;
				quo_q <= RPM_SCALE_Q8;
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end
			OP_DIV_STEP: begin
				rem_q <= rem_ge ? rem_diff[23:0] : rem_sh[23:0];
				quo_q <= {quo_q[22:0], rem_ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			OP_SAT: begin
				quo_q <= {6'd0, RPM_MAX_Q8};
			end
			OP_MUL: begin
				prod_q <= {13'd0, avg_q} * {18'd0, RADPS_FACTOR};
			end
			default: begin
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_led_q    <= led_q;
			out_acc_q    <= acc_q;
			out_period_q <= last_period_q;
			out_avg_q    <= avg_q;
			out_radps_q  <= prod_q[30:16];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_acc_q;
	assign m_axis_tdata  = {6'd0, out_radps_q, out_avg_q, out_period_q, out_led_q};

endmodule

>>> rtl/core/hta_checker.sv
// port-level checks for the hall tachometer, bound to the top level
// depends on: hall_tachometer_rpm_average_defines.svh, hall_tachometer_rpm_average
`include "hall_tachometer_rpm_average_defines.svh"

module hta_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	// a stalled result holds
	`HTA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	// the block leaves idle after taking a transaction
	`HTA_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken twice in a row")

	// a new measurement comes from a rising edge, which clears the led
	`HTA_ASSERT_NOW(a_meas_led_off, m_axis_tvalid && m_axis_tuser[0], !m_axis_tdata[0], "led on with a new measurement")

	// rad/s always follows the reported average
	`HTA_ASSERT_NOW(a_radps_match, m_axis_tvalid, m_axis_tdata[65:51] == 15'((33'(m_axis_tdata[50:33]) * 33'd6863) >> 16), "rad/s does not match average")

endmodule

bind hall_tachometer_rpm_average hta_checker u_hta_checker (.*);
